/* rtl/icdf_pkg.sv */
// Shared types, widths and codes for the inverse-CDF table sampler.
// No dependencies; every other file imports this package.
package icdf_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int IDX_W       = 8;
  localparam int POS_W       = 24;
  localparam int CDF_W       = 17;
  localparam int DRAW_W      = 16;
  localparam int USED_W      = 9;
  localparam int QUO_W       = POS_W;
  localparam int PROD_W      = DRAW_W + QUO_W;
  localparam int STEP_W      = $clog2(QUO_W);

  localparam logic [CDF_W-1:0] CDF_ONE   = 17'h10000;
  localparam logic [USED_W-1:0] USED_RST = 9'd2;

  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic [CDF_W-1:0]         cdf_t;
  typedef logic [DRAW_W-1:0]        draw_t;
  typedef logic [QUO_W-1:0]         quo_t;
  typedef logic [PROD_W-1:0]        prod_t;
  typedef logic [STEP_W-1:0]        step_t;

  typedef enum logic [1:0] {
    CLAMP_NONE  = 2'd0,
    CLAMP_FIRST = 2'd1,
    CLAMP_LAST  = 2'd2
  } clamp_e;

  typedef enum logic {
    MODE_LOAD   = 1'b0,
    MODE_SAMPLE = 1'b1
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FETCH_LO,
    ST_FETCH_HI,
    ST_DIVIDE,
    ST_POST
  } icdf_state_e;

  typedef struct packed {
    logic  en;
    addr_t addr;
    pos_t  pos;
    cdf_t  cum;
  } tbl_wr_t;

  typedef struct packed {
    logic  start;
    draw_t frac;
    quo_t  mag;
    cdf_t  den;
  } div_req_t;

  typedef struct packed {
    logic done;
    quo_t quo;
  } div_rsp_t;

endpackage

/* rtl/icdf_ifs.sv */
// Channel interfaces: sample/load requests, results and the config write.
// Depends on icdf_pkg.
interface icdf_req_if;
  import icdf_pkg::*;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [IDX_W-1:0]   entry_index;
  pos_t               entry_position;
  cdf_t               entry_cumulative;
  draw_t              uniform_draw;
  modport source (output valid, mode, entry_index, entry_position, entry_cumulative,
                  uniform_draw, input ready);
  modport sink (input valid, mode, entry_index, entry_position, entry_cumulative,
                uniform_draw, output ready);
endinterface

interface icdf_rsp_if;
  import icdf_pkg::*;
  logic       valid;
  logic       ready;
  pos_t       sampled_position;
  logic [1:0] clamp_status;
  modport source (output valid, sampled_position, clamp_status, input ready);
  modport sink (input valid, sampled_position, clamp_status, output ready);
endinterface

interface icdf_cfg_if;
  import icdf_pkg::*;
  logic              valid;
  logic              ready;
  logic [USED_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* rtl/icdf_table.sv */
// Position and cumulative-probability stores, one write and one read port.
// Read data is registered. Depends on icdf_pkg.
module icdf_table (
  input  logic              clk_i,
  input  icdf_pkg::tbl_wr_t wr_i,
  input  icdf_pkg::addr_t   rd_addr_i,
  output icdf_pkg::pos_t    rd_pos_o,
  output icdf_pkg::cdf_t    rd_cum_o
);
  import icdf_pkg::*;

  pos_t pos_mem [TABLE_DEPTH];
  cdf_t cum_mem [TABLE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      pos_mem[wr_i.addr] <= wr_i.pos;
      cum_mem[wr_i.addr] <= wr_i.cum;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_pos_o <= pos_mem[rd_addr_i];
    rd_cum_o <= cum_mem[rd_addr_i];
  end

endmodule

/* rtl/icdf_div.sv */
// Multiply-then-divide unit: a multiply step, then a restoring
// divider producing one quotient bit per cycle. Depends on icdf_pkg.
module icdf_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  icdf_pkg::div_req_t req_i,
  output icdf_pkg::div_rsp_t rsp_o
);
  import icdf_pkg::*;

  logic  busy_q, busy_d;
  logic  mul_q, mul_d;
  logic  done_q, done_d;
  step_t step_q, step_d;
  draw_t frac_q;
  quo_t  mag_q;
  cdf_t  den_q;
  cdf_t  rem_q, rem_d;
  quo_t  dvd_q, dvd_d;
  prod_t prod;
  logic [CDF_W:0] trial;
  logic [CDF_W:0] diff;

  assign prod  = prod_t'(frac_q) * prod_t'(mag_q);
  assign trial = {rem_q, dvd_q[QUO_W-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    mul_d  = mul_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      mul_d  = 1'b1;
    end else if (busy_q && mul_q) begin
      // quotient fits QUO_W bits, so the top bits are already below the divisor
      mul_d  = 1'b0;
      step_d = step_t'(QUO_W - 1);
      rem_d  = cdf_t'(prod[PROD_W-1:QUO_W]);
      dvd_d  = prod[QUO_W-1:0];
    end else if (busy_q) begin
      if (!diff[CDF_W]) begin
        rem_d = diff[CDF_W-1:0];
        dvd_d = {dvd_q[QUO_W-2:0], 1'b1};
      end else begin
        rem_d = trial[CDF_W-1:0];
        dvd_d = {dvd_q[QUO_W-2:0], 1'b0};
      end
      step_d = step_q - step_t'(1);
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      mul_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      mul_q  <= mul_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    rem_q  <= rem_d;
    dvd_q  <= dvd_d;
    if (req_i.start) begin
      frac_q <= req_i.frac;
      mag_q  <= req_i.mag;
      den_q  <= req_i.den;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = dvd_q;

endmodule

/* rtl/inverse_cdf_table_sampler_core.sv */
// Inverse-CDF table sampler top level: sequencer, config register, output slot.
// Depends on icdf_pkg, icdf_ifs, icdf_table and icdf_div.
//
// Usage:
//   cfg_i writes entries_used (clamped to 2..256 when used); it is always
//   ready and must only be written while the block is idle.
//   req_i carries load items (mode 0: write one table entry, cumulative values
//   above one are stored as one) and sample items (mode 1). A load gives no
//   result. A sample gives exactly one result on rsp_o. A sample runs a
//   binary search over the cumulative store, one probe per cycle through the
//   single table read port (up to 9 probes), then fetches the two bracketing
//   entries, or only the end entry for a clamped sample. Interpolated samples
//   go through the multiply/divide unit (a multiply step plus 24 one-bit
//   division steps) unless their cumulative difference is zero or negative.
//   req_i.ready is low while a sample is in flight.
//   Results wait in an output register; a new item is taken while it waits,
//   and a later sample holds in its last step until the register is free.
//   Reset clears control state and sets entries_used to 2; table contents
//   stay undefined until loaded.
module inverse_cdf_table_sampler_core (
  input  logic clk_i,
  input  logic rst_ni,
  icdf_cfg_if.sink   cfg_i,
  icdf_req_if.sink   req_i,
  icdf_rsp_if.source rsp_o
);
  import icdf_pkg::*;

  icdf_state_e state_q, state_d;

  logic [USED_W-1:0] used_q;
  cnt_t   n_in, mid0;
  cnt_t   n_q, lo_q, span_q, mid_q;
  cnt_t   half, lo_n, span_n, mid_n, fetch;
  draw_t  u_q;
  pos_t   x0_q;
  cdf_t   c0_q;
  logic   neg_q;
  pos_t   res_pos_q;
  clamp_e res_stat_q;
  logic   out_valid_q;
  pos_t   out_pos_q;
  clamp_e out_stat_q;

  tbl_wr_t  tbl_wr;
  addr_t    rd_addr;
  pos_t     rd_pos;
  cdf_t     rd_cum;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic   req_fire, sample_fire, out_free, out_load, is_clamp, den_bad;
  logic signed [POS_W:0] dx;
  logic [POS_W:0]        dx_mag;
  logic signed [CDF_W:0] den;
  logic [CDF_W:0]        du;
  quo_t   q_signed;

  icdf_table u_table (
    .clk_i     (clk_i),
    .wr_i      (tbl_wr),
    .rd_addr_i (rd_addr),
    .rd_pos_o  (rd_pos),
    .rd_cum_o  (rd_cum)
  );

  icdf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // config register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= USED_RST;
    end else if (cfg_i.valid) begin
      used_q <= cfg_i.data;
    end
  end

  always_comb begin
    if (used_q < USED_W'(2)) begin
      n_in = cnt_t'(2);
    end else if (32'(used_q) > TABLE_DEPTH) begin
      n_in = cnt_t'(TABLE_DEPTH);
    end else begin
      n_in = cnt_t'(used_q);
    end
  end
  assign mid0 = n_in >> 1;

  assign req_fire    = req_i.valid && req_i.ready;
  assign sample_fire = req_fire && (req_i.mode == MODE_SAMPLE);

  // load transfers write straight into the table
  always_comb begin
    tbl_wr.en   = req_fire && (req_i.mode == MODE_LOAD) &&
                  (32'(req_i.entry_index) < TABLE_DEPTH);
    tbl_wr.addr = addr_t'(req_i.entry_index);
    tbl_wr.pos  = req_i.entry_position;
    tbl_wr.cum  = (req_i.entry_cumulative > CDF_ONE) ? CDF_ONE : req_i.entry_cumulative;
  end

  // one search probe: rd_cum holds the entry at mid_q
  always_comb begin
    half = span_q >> 1;
    if (rd_cum < {1'b0, u_q}) begin
      lo_n   = mid_q + cnt_t'(1);
      span_n = span_q - half - cnt_t'(1);
    end else begin
      lo_n   = lo_q;
      span_n = half;
    end
    mid_n = lo_n + (span_n >> 1);
    if (lo_n == '0) begin
      fetch = '0;
    end else if (lo_n == n_q) begin
      fetch = n_q - cnt_t'(1);
    end else begin
      fetch = lo_n - cnt_t'(1);
    end
  end

  // interpolation operands: rd_* holds the upper entry here
  always_comb begin
    dx      = {rd_pos[POS_W-1], rd_pos} - {x0_q[POS_W-1], x0_q};
    dx_mag  = dx[POS_W] ? (~dx + 1'b1) : dx;
    den     = {1'b0, rd_cum} - {1'b0, c0_q};
    du      = {2'b00, u_q} - {1'b0, c0_q};
    den_bad = den[CDF_W] || (den == '0);
  end

  assign is_clamp = (lo_q == '0) || (lo_q == n_q);
  assign out_free = !out_valid_q || rsp_o.ready;
  assign q_signed = neg_q ? (~div_rsp.quo + 1'b1) : div_rsp.quo;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (sample_fire) state_d = ST_SEARCH;
      ST_SEARCH:   if (span_n == '0) state_d = ST_FETCH_LO;
      ST_FETCH_LO: state_d = is_clamp ? ST_POST : ST_FETCH_HI;
      ST_FETCH_HI: state_d = den_bad ? ST_POST : ST_DIVIDE;
      ST_DIVIDE:   if (div_rsp.done) state_d = ST_POST;
      ST_POST:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req_i.ready   = 1'b0;
    rd_addr       = '0;
    div_req.start = 1'b0;
    div_req.frac  = du[DRAW_W-1:0];
    div_req.mag   = dx_mag[QUO_W-1:0];
    div_req.den   = den[CDF_W-1:0];
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        rd_addr     = addr_t'(mid0);
      end
      ST_SEARCH: begin
        rd_addr = (span_n == '0) ? addr_t'(fetch) : addr_t'(mid_n);
      end
      ST_FETCH_LO: begin
        rd_addr = addr_t'(lo_q);
      end
      ST_FETCH_HI: begin
        div_req.start = !den_bad;
      end
      ST_POST: begin
        out_load = out_free;
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (sample_fire) begin
          u_q    <= req_i.uniform_draw;
          n_q    <= n_in;
          lo_q   <= '0;
          span_q <= n_in;
          mid_q  <= mid0;
        end
      end
      ST_SEARCH: begin
        lo_q   <= lo_n;
        span_q <= span_n;
        mid_q  <= mid_n;
      end
      ST_FETCH_LO: begin
        x0_q      <= rd_pos;
        c0_q      <= rd_cum;
        res_pos_q <= rd_pos;
        if (lo_q == '0) begin
          res_stat_q <= CLAMP_FIRST;
        end else if (lo_q == n_q) begin
          res_stat_q <= CLAMP_LAST;
        end else begin
          res_stat_q <= CLAMP_NONE;
        end
      end
      ST_FETCH_HI: begin
        neg_q <= dx[POS_W];
      end
      ST_DIVIDE: begin
        if (div_rsp.done) begin
          res_pos_q <= x0_q + pos_t'(q_signed);
        end
      end
      default: begin
        neg_q <= neg_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pos_q  <= res_pos_q;
      out_stat_q <= res_stat_q;
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.sampled_position = out_pos_q;
  assign rsp_o.clamp_status     = out_stat_q;

endmodule
